// File: hw/rtl/snp_pkg.sv
// Shared types and constants for the slice name parser.
package snp_pkg;

  localparam int SeriesW = 31;
  localparam int CountW  = 3;

  localparam logic [SeriesW-1:0] SERIES_LIMIT = 31'h7FFF_FFFF;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;

  localparam int PART_THREE_DIGITS = 100;

  localparam logic [CountW-1:0] COUNT_SAT   = 3'd4;
  localparam logic [CountW-1:0] COUNT_TWO   = 3'd2;
  localparam logic [CountW-1:0] COUNT_THREE = 3'd3;

  typedef enum logic [1:0] {
    PH_LETTERS = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_REJECT  = 2'd2
  } snp_phase_t;

  typedef struct packed {
    snp_phase_t         phase;
    logic [SeriesW-1:0] series_value;
    logic [CountW-1:0]  digit_count;
  } snp_state_t;

endpackage

// File: hw/rtl/slice_name_parser.sv
// Top level of the slice name parser: input register, step logic, result register.
// A result is registered when the last character of its name leaves the input register.
// Throughput: one character per cycle when not stalled; the input register and result
// register let a new character enter while a finished result waits to be taken.
// Reset (rst, synchronous, active high) empties both registers and returns the parser
// to the letters phase with all decoded values at zero.
module slice_name_parser import snp_pkg::*; #(
  parameter int MAX_PART_NUMBER = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         character,
  input  logic               last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic [SeriesW-1:0] series_index
);

  localparam int PartW = $clog2(MAX_PART_NUMBER + 1);

  logic               held_valid;
  logic [7:0]         held_char;
  logic               held_last;
  snp_state_t         st;
  snp_state_t         st_next;
  logic [PartW-1:0]   part_value;
  logic [PartW-1:0]   part_value_next;
  logic               step_ok;
  logic [SeriesW-1:0] step_index;
  logic               out_free;
  logic               advance;

  snp_step #(
    .MAX_PART_NUMBER(MAX_PART_NUMBER)
  ) u_step (
    .character      (held_char),
    .cur            (st),
    .part_value     (part_value),
    .nxt            (st_next),
    .part_value_next(part_value_next),
    .ok             (step_ok),
    .series_index   (step_index)
  );

  assign out_free = !out_valid || !out_stall;
  // Only a final character needs room in the result register.
  assign advance  = held_valid && (!held_last || out_free);
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_char <= character;
      held_last <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '{phase: PH_LETTERS, series_value: '0, digit_count: '0};
      part_value <= '0;
    end else if (advance) begin
      if (held_last) begin
        st         <= '{phase: PH_LETTERS, series_value: '0, digit_count: '0};
        part_value <= '0;
      end else begin
        st         <= st_next;
        part_value <= part_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && held_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_last) begin
      valid_res    <= step_ok;
      series_index <= step_index;
    end
  end

endmodule

// File: hw/rtl/snp_step.sv
// Next-state and result logic for one character of a slice name.
module snp_step import snp_pkg::*; #(
  parameter int MAX_PART_NUMBER = 256,
  localparam int PartW = $clog2(MAX_PART_NUMBER + 1)
) (
  input  logic [7:0]         character,
  input  snp_state_t         cur,
  input  logic [PartW-1:0]   part_value,
  output snp_state_t         nxt,
  output logic [PartW-1:0]   part_value_next,
  output logic               ok,
  output logic [SeriesW-1:0] series_index
);

  localparam int PartDiv = MAX_PART_NUMBER / 10;
  localparam int ProdW   = PartW + 4;

  logic                 is_upper;
  logic                 is_lower;
  logic                 is_digit;
  logic                 is_dash;
  logic [7:0]           letter_off;
  logic [4:0]           letter_val;
  logic [SeriesW+4:0]   series_wide;
  logic [SeriesW+4:0]   scaled;
  logic                 series_over;
  logic [7:0]           digit_off;
  logic [3:0]           digit_val;
  logic [ProdW-1:0]     part_wide;
  logic [ProdW-1:0]     part_prod;
  logic [CountW-1:0]    need;

  assign is_upper = (character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_Z);
  assign is_lower = (character >= CHAR_LOWER_A) && (character <= CHAR_LOWER_Z);
  assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
  assign is_dash  = (character == CHAR_DASH);

  assign letter_off = is_upper ? (character - CHAR_UPPER_A) : (character - CHAR_LOWER_A);
  assign letter_val = letter_off[4:0] + 5'd1;

  // series * 26 + letter, formed by shifts; it overflows when it passes 2^31-1.
  assign series_wide = {5'd0, cur.series_value};
  assign scaled      = (series_wide << 4) + (series_wide << 3) + (series_wide << 1)
                     + {{(SeriesW){1'b0}}, letter_val};
  assign series_over = scaled > {5'd0, SERIES_LIMIT};

  assign digit_off = character - CHAR_ZERO;
  assign digit_val = digit_off[3:0];
  assign part_wide = {4'd0, part_value};
  assign part_prod = (part_wide << 3) + (part_wide << 1) + {{(PartW){1'b0}}, digit_val};

  always_comb begin
    nxt             = cur;
    part_value_next = part_value;
    unique case (cur.phase)
      PH_LETTERS: begin
        if (is_upper || is_lower) begin
          if (series_over) begin
            nxt.phase = PH_REJECT;
          end else begin
            nxt.series_value = scaled[SeriesW-1:0];
          end
        end else if (is_dash && (cur.series_value != '0)) begin
          nxt.phase = PH_DIGITS;
        end else begin
          nxt.phase = PH_REJECT;
        end
      end
      PH_DIGITS: begin
        if (!is_digit) begin
          nxt.phase = PH_REJECT;
        end else if (part_value > PartW'(PartDiv)) begin
          nxt.phase = PH_REJECT;
        end else begin
          // The part value is stored even when it runs past the limit.
          part_value_next = part_prod[PartW-1:0];
          if (part_prod > ProdW'(MAX_PART_NUMBER)) begin
            nxt.phase = PH_REJECT;
          end else if (cur.digit_count < COUNT_SAT) begin
            nxt.digit_count = cur.digit_count + 3'd1;
          end
        end
      end
      default: begin
        nxt.phase = cur.phase;
      end
    endcase
  end

  assign need = (part_value_next < PartW'(PART_THREE_DIGITS)) ? COUNT_TWO : COUNT_THREE;

  assign ok = (nxt.phase == PH_DIGITS) && (part_value_next != '0)
           && (nxt.digit_count == need) && (nxt.series_value != '0);

  assign series_index = ok ? (nxt.series_value - 31'd1) : '0;

endmodule

// File: hw/rtl/snp_checker.sv
// Port-level checks for the slice name parser, bound to the top level.
module snp_checker import snp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         character,
  input logic               last_char,
  input logic               out_valid,
  input logic               out_stall,
  input logic               valid_res,
  input logic [SeriesW-1:0] series_index
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(character) && $stable(last_char))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valid_res) && $stable(series_index))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> series_index == '0)
    else $error("rejected name carries a nonzero index");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side is free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

endmodule

bind slice_name_parser snp_checker u_snp_checker (.*);

// File: verif/tb_top.sv
// Testbench for the slice name parser: random and directed names checked against a model.
`timescale 1ns / 1ps

class slice_label_tracker;
  typedef struct {
    logic                               ok;
    logic [snp_pkg::SeriesW-1:0]        index;
  } label_t;

  label_t              expected_labels[$];
  snp_pkg::snp_phase_t phase;
  int unsigned         series;
  int unsigned         part;
  int unsigned         digits;
  int unsigned         part_max;
  int unsigned         errors;

  function new(int unsigned max_part);
    part_max = max_part;
    errors   = 0;
    clear();
  endfunction

  function void clear();
    phase  = snp_pkg::PH_LETTERS;
    series = 0;
    part   = 0;
    digits = 0;
  endfunction

  function int unsigned pending();
    return expected_labels.size();
  endfunction

  // Advances the decoder by one accepted item and queues a label on the last one.
  function void note_char(byte unsigned c, bit last);
    int unsigned letter;
    int unsigned limit;
    int unsigned need;
    label_t      got;
    limit  = snp_pkg::SERIES_LIMIT;
    letter = 0;
    if (phase == snp_pkg::PH_LETTERS) begin
      if (c >= snp_pkg::CHAR_UPPER_A && c <= snp_pkg::CHAR_UPPER_Z) begin
        letter = c - snp_pkg::CHAR_UPPER_A + 1;
      end else if (c >= snp_pkg::CHAR_LOWER_A && c <= snp_pkg::CHAR_LOWER_Z) begin
        letter = c - snp_pkg::CHAR_LOWER_A + 1;
      end
      if (letter != 0) begin
        if (series > (limit - letter) / 26) begin
          phase = snp_pkg::PH_REJECT;
        end else begin
          series = series * 26 + letter;
        end
      end else if (c == snp_pkg::CHAR_DASH && series != 0) begin
        phase = snp_pkg::PH_DIGITS;
      end else begin
        phase = snp_pkg::PH_REJECT;
      end
    end else if (phase == snp_pkg::PH_DIGITS) begin
      if (c < snp_pkg::CHAR_ZERO || c > snp_pkg::CHAR_NINE) begin
        phase = snp_pkg::PH_REJECT;
      end else if (part > part_max / 10) begin
        phase = snp_pkg::PH_REJECT;
      end else begin
        part = part * 10 + (c - snp_pkg::CHAR_ZERO);
        if (part > part_max) begin
          phase = snp_pkg::PH_REJECT;
        end else if (digits < snp_pkg::COUNT_SAT) begin
          digits++;
        end
      end
    end
    if (last) begin
      need = (part < snp_pkg::PART_THREE_DIGITS) ? snp_pkg::COUNT_TWO : snp_pkg::COUNT_THREE;
      got.ok = (phase == snp_pkg::PH_DIGITS) && part != 0 && digits == need && series != 0;
      got.index = got.ok ? snp_pkg::SeriesW'(series - 1) : '0;
      expected_labels.push_back(got);
      clear();
    end
  endfunction

  function void check_label(logic valid_res, logic [snp_pkg::SeriesW-1:0] series_index);
    label_t want;
    if (expected_labels.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected: valid_res %0b series_index %0d",
               $time, valid_res, series_index);
      return;
    end
    want = expected_labels.pop_front();
    if (valid_res !== want.ok) begin
      errors++;
      $display("%0t: valid_res expected %0b got %0b", $time, want.ok, valid_res);
    end
    if (series_index !== want.index) begin
      errors++;
      $display("%0t: series_index expected %0d got %0d", $time, want.index, series_index);
    end
  endfunction
endclass

module tb_top;
  import snp_pkg::*;

  localparam int          MaxPart    = 256;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandChars  = 850;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         character = 8'h00;
  logic               last_char = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               valid_res;
  logic [SeriesW-1:0] series_index;

  byte unsigned       name_buf[$];
  int unsigned        src_gap_max  = 9;
  int unsigned        sink_gap_max = 9;
  int unsigned        chars_sent   = 0;
  int unsigned        cycle_count  = 0;
  slice_label_tracker labels       = new(MaxPart);

  string plain_names[] = '{
    "A-01", "z-99", "Az-100", "zZ-256", "B-257", "C-1", "C-001", "C-00", "D-00001",
    "-12", "AB", "AB-", "AB-1x", "A7-12", "A--12", "@-12", "a[-12", "`-12", "b{-12",
    "A-/1", "A-1:", "A-260", "A-259", "A-0", "A"
  };

  slice_name_parser #(.MAX_PART_NUMBER(MaxPart)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .valid_res    (valid_res),
    .series_index (series_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  function void add_text(string s);
    foreach (s[i]) name_buf.push_back(s[i]);
  endfunction

  // Letters for a bijective base-26 value, each in a random case.
  function void add_series(longint unsigned v);
    byte unsigned    letters[$];
    longint unsigned rest;
    byte unsigned    ch;
    rest = v;
    while (rest != 0) begin
      rest = rest - 1;
      ch = CHAR_UPPER_A + 8'(rest % 26);
      if ($urandom_range(0, 1) == 1) ch = ch - CHAR_UPPER_A + CHAR_LOWER_A;
      letters.push_front(ch);
      rest = rest / 26;
    end
    foreach (letters[i]) name_buf.push_back(letters[i]);
  endfunction

  function void add_part(int unsigned p, int unsigned w);
    int unsigned scale;
    scale = 1;
    repeat (w - 1) scale *= 10;
    repeat (w) begin
      name_buf.push_back(CHAR_ZERO + 8'((p / scale) % 10));
      scale /= 10;
    end
  endfunction

  task automatic send_name();
    int unsigned gap;
    foreach (name_buf[i]) begin
      gap = $urandom_range(0, src_gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      character <= name_buf[i];
      last_char <= (i == name_buf.size() - 1);
      do @(posedge clk); while (in_stall);
      labels.note_char(name_buf[i], i == name_buf.size() - 1);
      chars_sent++;
    end
    name_buf.delete();
  endtask

  // The extra edge keeps the next item from being driven in the same time step.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (labels.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stall before each item, then wait for it.
  initial begin
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      hold = $urandom_range(0, sink_gap_max);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      labels.check_label(valid_res, series_index);
    end
  end

  initial begin
    int unsigned     names_done;
    int unsigned     kind;
    int unsigned     pick;
    int unsigned     flaw;
    int unsigned     part;
    int unsigned     width;
    int unsigned     pos;
    int unsigned     start_chars;
    longint unsigned series;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plain_names[i]) begin
      add_text(plain_names[i]);
      send_name();
    end
    // Largest letter value that fits, one letter past it, and one just over it.
    add_series(SERIES_LIMIT);
    add_text("-10");
    send_name();
    add_series(SERIES_LIMIT);
    add_text("A-10");
    send_name();
    add_series(longint'(SERIES_LIMIT) + 1);
    add_text("-100");
    send_name();
    name_buf.push_back(8'h00);
    send_name();
    name_buf.push_back(8'hFF);
    add_text("A-12");
    send_name();

    drain();

    names_done  = 0;
    start_chars = chars_sent;
    while (chars_sent - start_chars < RandChars) begin
      if (names_done % 16 == 0) begin
        src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 9;
        sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      end
      if (names_done == 60) drain();
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          series = $urandom_range(1, 800);
        end else if (pick < 9) begin
          series = $urandom_range(1, SERIES_LIMIT);
        end else begin
          series = SERIES_LIMIT - $urandom_range(0, 30);
        end
        part  = $urandom_range(1, MaxPart);
        width = (part < PART_THREE_DIGITS) ? 2 : 3;
        flaw  = (kind >= 70) ? $urandom_range(0, 6) : 7;
        case (flaw)
          0: width = ($urandom_range(0, 1) == 1) ? width + 1 : width - 1;
          1: part = 0;
          2: begin
            part  = $urandom_range(MaxPart + 1, 999);
            width = 3;
          end
          3: series = longint'(SERIES_LIMIT) + $urandom_range(1, 5000);
          default: ;
        endcase
        add_series(series);
        add_text("-");
        add_part(part, width);
        if (flaw >= 4 && flaw <= 6) begin
          pos = $urandom_range(0, name_buf.size() - 1);
          if (flaw == 4) begin
            name_buf.insert(pos, 8'($urandom_range(0, 255)));
          end else if (flaw == 5) begin
            name_buf.delete(pos);
          end else begin
            while (name_buf.size() > pos + 1) void'(name_buf.pop_back());
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) name_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_name();
      names_done++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (labels.errors == 0 && labels.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/snp_pkg.sv
hw/rtl/snp_step.sv
hw/rtl/slice_name_parser.sv
hw/rtl/snp_checker.sv
verif/tb_top.sv
